// File: rtl/rcpg_pkg.sv
`default_nettype none
package rcpg_pkg;

	localparam int PIX_W      = 7;
	localparam int CH_W       = 8;
	localparam int HUE_W      = 8;
	localparam int TS_W       = 64;
	localparam int IVL_W      = 32;
	localparam int APB_AW     = 4;
	localparam int APB_DW     = 32;

	localparam logic [HUE_W-1:0] HUE_MOD     = 8'd255;
	localparam logic [HUE_W-1:0] HUE_TOP     = 8'd254;
	localparam logic [HUE_W-1:0] REGION_SPAN = 8'd43;
	localparam logic [HUE_W-1:0] REM_SCALE   = 8'd6;
	localparam int               MAX_RESULTS = 64;

	localparam logic [IVL_W-1:0] RST_INTERVAL    = 32'd20000;
	localparam logic [PIX_W-1:0] RST_FIRST_PIXEL = 7'd3;
	localparam logic [CH_W-1:0]  RST_SATURATION  = 8'd255;
	localparam logic [CH_W-1:0]  RST_VALUE       = 8'd255;

	typedef enum logic [1:0] {
		CFG_INTERVAL    = 2'd0,
		CFG_FIRST_PIXEL = 2'd1,
		CFG_SATURATION  = 2'd2,
		CFG_VALUE       = 2'd3
	} cfg_reg_t;

	typedef enum logic [2:0] {
		SEC_R_TO_Y = 3'd0,
		SEC_Y_TO_G = 3'd1,
		SEC_G_TO_C = 3'd2,
		SEC_C_TO_B = 3'd3,
		SEC_B_TO_M = 3'd4,
		SEC_M_TO_R = 3'd5
	} hue_sector_t;

	typedef struct packed {
		logic [PIX_W-1:0] first_pixel;
		logic [CH_W-1:0]  saturation;
		logic [CH_W-1:0]  value;
	} color_cfg_t;

endpackage
`default_nettype wire

// File: rtl/rcpg_if.sv
`default_nettype none
interface rcpg_req_if;
	logic                          valid;
	logic                          ready;
	logic [rcpg_pkg::TS_W-1:0]     timestamp_us;

	modport source (output valid, output timestamp_us, input ready);
	modport sink (input valid, input timestamp_us, output ready);
endinterface

interface rcpg_pix_if;
	logic                          valid;
	logic                          ready;
	logic [rcpg_pkg::PIX_W-1:0]    pixel_index;
	logic [rcpg_pkg::CH_W-1:0]     red;
	logic [rcpg_pkg::CH_W-1:0]     green;
	logic [rcpg_pkg::CH_W-1:0]     blue;
	logic                          last_pixel;

	modport source (output valid, output pixel_index, output red, output green, output blue,
		output last_pixel, input ready);
	modport sink (input valid, input pixel_index, input red, input green, input blue,
		input last_pixel, output ready);
endinterface
`default_nettype wire

// File: rtl/rcpg_front.sv
`default_nettype none
module rcpg_front #(
	parameter int NUM_PIXELS = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	rcpg_req_if.sink                           req,
	input  wire logic [rcpg_pkg::IVL_W-1:0]    interval,
	input  wire logic [rcpg_pkg::PIX_W-1:0]    first_pixel,
	input  wire logic                          queue_full,
	output logic                               push,
	output logic [rcpg_pkg::HUE_W-1:0]         push_hue
);

	logic [rcpg_pkg::HUE_W-1:0] hue_q;
	logic [rcpg_pkg::TS_W-1:0]  last_time_q;
	logic [rcpg_pkg::TS_W-1:0]  elapsed;
	logic                       advance;
	logic                       accept;
	logic [rcpg_pkg::HUE_W-1:0] next_hue;

	assign req.ready = !queue_full;
	assign accept    = req.valid && !queue_full;
	assign elapsed   = req.timestamp_us - last_time_q;
	assign advance   = elapsed >= {{(rcpg_pkg::TS_W-rcpg_pkg::IVL_W){1'b0}}, interval};

	always_comb begin
		next_hue = hue_q;
		if (advance) begin
			next_hue = (hue_q == rcpg_pkg::HUE_TOP) ? '0 : hue_q + 8'd1;
		end
	end

	// frames that start past the strip end produce nothing for the back end
	assign push     = accept && (first_pixel < rcpg_pkg::PIX_W'(NUM_PIXELS));
	assign push_hue = next_hue;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hue_q       <= '0;
			last_time_q <= '0;
		end else if (accept) begin
			hue_q <= next_hue;
			if (advance) begin
				last_time_q <= req.timestamp_us;
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/rcpg_queue.sv
`default_nettype none
module rcpg_queue (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          push,
	input  wire logic [rcpg_pkg::HUE_W-1:0]    push_hue,
	input  wire logic                          pop,
	output logic                               full,
	output logic                               empty,
	output logic [rcpg_pkg::HUE_W-1:0]         head_hue
);

	logic [rcpg_pkg::HUE_W-1:0] mem_q [2];
	logic                       wr_ptr_q;
	logic                       rd_ptr_q;
	logic [1:0]                 count_q;

	assign full     = count_q == 2'd2;
	assign empty    = count_q == 2'd0;
	assign head_hue = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_hue;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/rcpg_back.sv
`default_nettype none
module rcpg_back #(
	parameter int NUM_PIXELS = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire rcpg_pkg::color_cfg_t          cfg,
	input  wire logic                          queue_empty,
	input  wire logic [rcpg_pkg::HUE_W-1:0]    head_hue,
	output logic                               pop,
	rcpg_pix_if.source                         pix
);

	localparam int IDX_W = (NUM_PIXELS > 1) ? $clog2(NUM_PIXELS) : 1;
	localparam logic [rcpg_pkg::PIX_W-1:0] LAST_STRIP = rcpg_pkg::PIX_W'(NUM_PIXELS - 1);

	logic [rcpg_pkg::HUE_W-1:0] offs [NUM_PIXELS];

	for (genvar g = 0; g < NUM_PIXELS; g++) begin : g_offs
		assign offs[g] = rcpg_pkg::HUE_W'((g * 255) / NUM_PIXELS);
	end

	logic                        en;
	logic                        busy_q;
	logic [rcpg_pkg::PIX_W-1:0]  idx_q;
	logic [rcpg_pkg::HUE_W-1:0]  base_q;
	logic [rcpg_pkg::PIX_W-1:0]  last_idx;
	logic [rcpg_pkg::PIX_W:0]    run_lim;
	logic                        issue;
	logic                        at_last;

	logic [rcpg_pkg::HUE_W:0]    hue_sum;
	logic [rcpg_pkg::HUE_W-1:0]  hue;

	logic                        valid_s1;
	logic [rcpg_pkg::PIX_W-1:0]  idx_s1;
	logic [rcpg_pkg::HUE_W-1:0]  hue_s1;
	logic                        last_s1;

	rcpg_pkg::hue_sector_t       sector;
	logic [rcpg_pkg::HUE_W-1:0]  sector_lo;
	logic [rcpg_pkg::HUE_W-1:0]  diff;
	logic [rcpg_pkg::HUE_W+2:0]  rem_wide;
	logic [rcpg_pkg::HUE_W-1:0]  rem;
	logic [2*rcpg_pkg::CH_W-1:0] p_prod;
	logic [2*rcpg_pkg::CH_W-1:0] sr_prod;
	logic [2*rcpg_pkg::CH_W-1:0] srn_prod;

	logic                        valid_s2;
	logic [rcpg_pkg::PIX_W-1:0]  idx_s2;
	logic                        last_s2;
	rcpg_pkg::hue_sector_t       sector_s2;
	logic [rcpg_pkg::CH_W-1:0]   p_s2;
	logic [rcpg_pkg::CH_W-1:0]   sr_s2;
	logic [rcpg_pkg::CH_W-1:0]   srn_s2;

	logic [2*rcpg_pkg::CH_W-1:0] q_prod;
	logic [2*rcpg_pkg::CH_W-1:0] t_prod;
	logic [rcpg_pkg::CH_W-1:0]   q_val;
	logic [rcpg_pkg::CH_W-1:0]   t_val;
	logic [rcpg_pkg::CH_W-1:0]   r_next;
	logic [rcpg_pkg::CH_W-1:0]   g_next;
	logic [rcpg_pkg::CH_W-1:0]   b_next;

	logic                        valid_s3;
	logic [rcpg_pkg::PIX_W-1:0]  idx_s3;
	logic                        last_s3;
	logic [rcpg_pkg::CH_W-1:0]   r_s3;
	logic [rcpg_pkg::CH_W-1:0]   g_s3;
	logic [rcpg_pkg::CH_W-1:0]   b_s3;

	assign en      = !valid_s3 || pix.ready;
	assign pop     = !busy_q && !queue_empty;
	assign issue   = busy_q && en;
	assign run_lim = {1'b0, cfg.first_pixel} + 8'(rcpg_pkg::MAX_RESULTS - 1);
	assign last_idx = (run_lim < {1'b0, LAST_STRIP}) ? run_lim[rcpg_pkg::PIX_W-1:0] : LAST_STRIP;
	assign at_last = idx_q == last_idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (pop) begin
			busy_q <= 1'b1;
		end else if (issue && at_last) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			idx_q  <= cfg.first_pixel;
			base_q <= head_hue;
		end else if (issue) begin
			idx_q <= idx_q + 7'd1;
		end
	end

	// stage 1: pixel hue
	assign hue_sum = {1'b0, base_q} + {1'b0, offs[idx_q[IDX_W-1:0]]};
	assign hue     = (hue_sum >= {1'b0, rcpg_pkg::HUE_MOD}) ?
		rcpg_pkg::HUE_W'(hue_sum - {1'b0, rcpg_pkg::HUE_MOD}) : hue_sum[rcpg_pkg::HUE_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			idx_s1  <= idx_q;
			hue_s1  <= hue;
			last_s1 <= at_last;
		end
	end

	// stage 2: sector, remainder and first products
	always_comb begin
		priority if (hue_s1 < rcpg_pkg::REGION_SPAN) begin
			sector = rcpg_pkg::SEC_R_TO_Y;
			sector_lo = 8'd0;
		end else if (hue_s1 < 8'd86) begin
			sector = rcpg_pkg::SEC_Y_TO_G;
			sector_lo = 8'd43;
		end else if (hue_s1 < 8'd129) begin
			sector = rcpg_pkg::SEC_G_TO_C;
			sector_lo = 8'd86;
		end else if (hue_s1 < 8'd172) begin
			sector = rcpg_pkg::SEC_C_TO_B;
			sector_lo = 8'd129;
		end else if (hue_s1 < 8'd215) begin
			sector = rcpg_pkg::SEC_B_TO_M;
			sector_lo = 8'd172;
		end else begin
			sector = rcpg_pkg::SEC_M_TO_R;
			sector_lo = 8'd215;
		end
	end

	assign diff     = hue_s1 - sector_lo;
	assign rem_wide = {3'b0, diff} * {3'b0, rcpg_pkg::REM_SCALE};
	assign rem      = rem_wide[rcpg_pkg::HUE_W-1:0];
	assign p_prod   = {8'd0, cfg.value} * {8'd0, rcpg_pkg::HUE_MOD - cfg.saturation};
	assign sr_prod  = {8'd0, cfg.saturation} * {8'd0, rem};
	assign srn_prod = {8'd0, cfg.saturation} * {8'd0, rcpg_pkg::HUE_MOD - rem};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			idx_s2    <= idx_s1;
			last_s2   <= last_s1;
			sector_s2 <= sector;
			p_s2      <= p_prod[2*rcpg_pkg::CH_W-1:rcpg_pkg::CH_W];
			sr_s2     <= sr_prod[2*rcpg_pkg::CH_W-1:rcpg_pkg::CH_W];
			srn_s2    <= srn_prod[2*rcpg_pkg::CH_W-1:rcpg_pkg::CH_W];
		end
	end

	// stage 3: ramps and channel routing
	assign q_prod = {8'd0, cfg.value} * {8'd0, rcpg_pkg::HUE_MOD - sr_s2};
	assign t_prod = {8'd0, cfg.value} * {8'd0, rcpg_pkg::HUE_MOD - srn_s2};
	assign q_val  = q_prod[2*rcpg_pkg::CH_W-1:rcpg_pkg::CH_W];
	assign t_val  = t_prod[2*rcpg_pkg::CH_W-1:rcpg_pkg::CH_W];

	always_comb begin
		r_next = cfg.value;
		g_next = p_s2;
		b_next = q_val;
		if (cfg.saturation == '0) begin
			g_next = cfg.value;
			b_next = cfg.value;
		end else begin
			unique case (sector_s2)
				rcpg_pkg::SEC_R_TO_Y: begin
					r_next = cfg.value; g_next = t_val; b_next = p_s2;
				end
				rcpg_pkg::SEC_Y_TO_G: begin
					r_next = q_val; g_next = cfg.value; b_next = p_s2;
				end
				rcpg_pkg::SEC_G_TO_C: begin
					r_next = p_s2; g_next = cfg.value; b_next = t_val;
				end
				rcpg_pkg::SEC_C_TO_B: begin
					r_next = p_s2; g_next = q_val; b_next = cfg.value;
				end
				rcpg_pkg::SEC_B_TO_M: begin
					r_next = t_val; g_next = p_s2; b_next = cfg.value;
				end
				default: begin
					r_next = cfg.value; g_next = p_s2; b_next = q_val;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			idx_s3  <= idx_s2;
			last_s3 <= last_s2;
			r_s3    <= r_next;
			g_s3    <= g_next;
			b_s3    <= b_next;
		end
	end

	assign pix.valid       = valid_s3;
	assign pix.pixel_index = idx_s3;
	assign pix.red         = r_s3;
	assign pix.green       = g_s3;
	assign pix.blue        = b_s3;
	assign pix.last_pixel  = last_s3;

endmodule
`default_nettype wire

// File: rtl/rainbow_chase_pixel_generator.sv
// a request is taken while the frame queue is not full; its pixels pass through the
// sequencer and pixel stages, one pixel per cycle unless pix.ready stalls; per frame
// min(NUM_PIXELS - first_pixel, 64) pixels; a frame loads when the sequencer is idle
// a two-entry frame queue lets requests be taken while the previous frame still streams
// reset: registers return to their defaults, base hue and advance time clear, queue empties
`default_nettype none
module rainbow_chase_pixel_generator #(
	parameter int NUM_PIXELS = 32
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	rcpg_req_if.sink                            req,
	rcpg_pix_if.source                          pix,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [rcpg_pkg::APB_AW-1:0]    paddr,
	input  wire logic [rcpg_pkg::APB_DW-1:0]    pwdata,
	output logic [rcpg_pkg::APB_DW-1:0]         prdata,
	output logic                                pready
);

	logic [rcpg_pkg::IVL_W-1:0] interval_q;
	logic [rcpg_pkg::PIX_W-1:0] first_pixel_q;
	logic [rcpg_pkg::CH_W-1:0]  saturation_q;
	logic [rcpg_pkg::CH_W-1:0]  value_q;
	rcpg_pkg::cfg_reg_t         reg_sel;
	logic                       wr_en;

	logic                       push;
	logic [rcpg_pkg::HUE_W-1:0] push_hue;
	logic                       pop;
	logic                       queue_full;
	logic                       queue_empty;
	logic [rcpg_pkg::HUE_W-1:0] head_hue;
	rcpg_pkg::color_cfg_t       color_cfg;

	assign pready  = 1'b1;
	assign reg_sel = rcpg_pkg::cfg_reg_t'(paddr[3:2]);
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q    <= rcpg_pkg::RST_INTERVAL;
			first_pixel_q <= rcpg_pkg::RST_FIRST_PIXEL;
			saturation_q  <= rcpg_pkg::RST_SATURATION;
			value_q       <= rcpg_pkg::RST_VALUE;
		end else if (wr_en) begin
			unique case (reg_sel)
				rcpg_pkg::CFG_INTERVAL:    interval_q    <= pwdata;
				rcpg_pkg::CFG_FIRST_PIXEL: first_pixel_q <= pwdata[rcpg_pkg::PIX_W-1:0];
				rcpg_pkg::CFG_SATURATION:  saturation_q  <= pwdata[rcpg_pkg::CH_W-1:0];
				rcpg_pkg::CFG_VALUE:       value_q       <= pwdata[rcpg_pkg::CH_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			rcpg_pkg::CFG_INTERVAL:    prdata = interval_q;
			rcpg_pkg::CFG_FIRST_PIXEL: prdata = {25'b0, first_pixel_q};
			rcpg_pkg::CFG_SATURATION:  prdata = {24'b0, saturation_q};
			rcpg_pkg::CFG_VALUE:       prdata = {24'b0, value_q};
		endcase
	end

	assign color_cfg.first_pixel = first_pixel_q;
	assign color_cfg.saturation  = saturation_q;
	assign color_cfg.value       = value_q;

	rcpg_front #(
		.NUM_PIXELS (NUM_PIXELS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.interval    (interval_q),
		.first_pixel (first_pixel_q),
		.queue_full  (queue_full),
		.push        (push),
		.push_hue    (push_hue)
	);

	rcpg_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_hue (push_hue),
		.pop      (pop),
		.full     (queue_full),
		.empty    (queue_empty),
		.head_hue (head_hue)
	);

	rcpg_back #(
		.NUM_PIXELS (NUM_PIXELS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (color_cfg),
		.queue_empty (queue_empty),
		.head_hue    (head_hue),
		.pop         (pop),
		.pix         (pix)
	);

endmodule
`default_nettype wire
